### design/qdsw_pkg.sv
// Shared types, codes and widths for the quadrature decoder with windowed speed.
// No dependencies; imported by every module of the block.
package qdsw_pkg;

    localparam int POS_W      = 32;
    localparam int TIMER_W    = 32;
    localparam int SUM_W      = 40;
    localparam int SPEED_W    = 48;
    localparam int Q_SHIFT    = 16;
    localparam int DIV_W      = POS_W + Q_SHIFT;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int WINDOW_DEF      = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 32'd150000;

    localparam logic [CFG_ADDR_W-1:0] REG_DECODE_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_EN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [1:0] MODE_X1   = 2'd0;
    localparam logic [1:0] MODE_X2   = 2'd1;
    localparam logic [1:0] MODE_X4   = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_READ  = 2'd1,
        K_RESET = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         decode_mode;
        logic               measure_en;
        logic [TIMER_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic             counted;
        logic             dbl;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] delta;
    } t_cmd;

endpackage

### design/qdsw_front.sv
// Front end: takes input words, decodes pin edges and keeps position counters.
// Pushes one classified command per word into the queue. Uses qdsw_pkg.
module qdsw_front import qdsw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic       i_pin_a,
    input  logic       i_pin_b,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_last, n_last;
    logic [1:0]       r_prev, n_prev;

    logic [1:0]       mode;
    logic             chg_a, chg_b;
    logic             counted, step_up, dbl;
    logic [POS_W-1:0] delta;
    t_kind            kind;

    assign kind    = t_kind'(i_kind);
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        mode    = (i_cfg.decode_mode == MODE_RSVD) ? MODE_X1 : i_cfg.decode_mode;
        chg_a   = i_pin_a != r_prev[0];
        chg_b   = i_pin_b != r_prev[1];
        counted = 1'b0;
        step_up = 1'b0;
        dbl     = 1'b0;
        delta   = '0;
        n_pos   = r_pos;
        n_last  = r_last;
        n_prev  = r_prev;
        unique case (kind)
            K_TICK: begin
                n_prev = {i_pin_b, i_pin_a};
                if (chg_a && chg_b) begin
                    dbl = 1'b1;
                end else if (chg_a) begin
                    if (i_pin_a) begin
                        counted = 1'b1;
                        step_up = !i_pin_b;
                    end else if (mode == MODE_X2 || mode == MODE_X4) begin
                        counted = 1'b1;
                        step_up = i_pin_b;
                    end
                end else if (chg_b && mode == MODE_X4) begin
                    counted = 1'b1;
                    step_up = i_pin_b ? i_pin_a : !i_pin_a;
                end
                if (counted) begin
                    n_pos = step_up ? r_pos + 1'b1 : r_pos - 1'b1;
                end
            end
            K_READ: begin
                delta  = r_pos - r_last;
                n_last = r_pos;
            end
            K_RESET: begin
                n_pos  = '0;
                n_last = '0;
            end
            K_NONE: begin
            end
        endcase
    end

    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.counted = counted;
        o_cmd.dbl     = dbl;
        o_cmd.pos     = n_pos;
        o_cmd.delta   = delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_last <= '0;
            r_prev <= 2'b11;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_last <= n_last;
            r_prev <= n_prev;
        end
    end

endmodule

### design/qdsw_queue.sv
// Small command queue between the decoder front end and the measurement back end.
// Holds t_cmd entries from qdsw_pkg.
module qdsw_queue import qdsw_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/qdsw_back.sv
// Back end: interval timer, sample rings, window sum, bit-serial divider for speed,
// timeout handling and the output register. Uses qdsw_pkg.
module qdsw_back import qdsw_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [POS_W-1:0]   o_position,
    output logic [POS_W-1:0]   o_delta,
    output logic [SPEED_W-1:0] o_speed,
    output logic               o_dbl,
    output logic               o_tout
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(DIV_W);

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_OUT} t_state;

    t_state             r_state, n_state;
    logic               r_started, n_started;
    logic               r_full, n_full;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [TIMER_W-1:0] r_now, n_now;
    t_cmd               r_cur, n_cur;
    logic               r_neg, n_neg;
    logic [SUM_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_dvd, n_dvd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               r_out_valid, n_out_valid;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic [POS_W-1:0]   r_out_delta, n_out_delta;
    logic [SPEED_W-1:0] r_out_speed, n_out_speed;
    logic               r_out_dbl, n_out_dbl;
    logic               r_out_tout, n_out_tout;

    // sample rings
    logic [TIMER_W-1:0] r_int_mem [WINDOW];
    logic [POS_W-1:0]   r_pos_mem [WINDOW];
    logic [WINDOW-1:0]  r_int_vld;
    logic [TIMER_W-1:0] r_int_rd;
    logic               r_int_rd_vld;
    logic [POS_W-1:0]   r_pos_rd;
    logic [SLOT_W-1:0]  pos_rd_addr;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wr_addr;
    logic [TIMER_W-1:0] int_wr_data;
    logic [POS_W-1:0]   pos_wr_data;

    logic               out_free, q_pop, edge_item, load;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] old_int;
    logic [POS_W-1:0]   diff, mag;
    logic [SUM_W:0]     rem_sh;
    logic               ge;
    logic               last_slot;

    assign out_free    = !r_out_valid || i_ready;
    assign edge_item   = i_cmd.kind == K_TICK && i_cmd.counted && i_cfg.measure_en;
    assign q_pop       = r_state == S_IDLE && i_q_valid
                         && ((edge_item && r_started) || out_free);
    assign o_q_pop     = q_pop;
    assign timer_inc   = (r_started && r_timer != '1) ? r_timer + 1'b1 : r_timer;
    assign pos_rd_addr = r_full ? r_slot : '0;
    assign old_int     = r_int_rd_vld ? r_int_rd : '0;
    assign last_slot   = r_slot == SLOT_W'(WINDOW - 1);
    assign diff        = r_cur.pos - r_pos_rd;
    assign mag         = diff[POS_W-1] ? -diff : diff;
    assign rem_sh      = {r_rem, r_dvd[DIV_W-1]};
    assign ge          = rem_sh >= {1'b0, r_sum};

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_full      = r_full;
        n_slot      = r_slot;
        n_timer     = r_timer;
        n_sum       = r_sum;
        n_speed     = r_speed;
        n_now       = r_now;
        n_cur       = r_cur;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pos   = r_out_pos;
        n_out_delta = '0;
        n_out_dbl   = 1'b0;
        n_out_tout  = 1'b0;
        load        = 1'b0;
        mem_we      = 1'b0;
        mem_wr_addr = r_slot;
        int_wr_data = r_now;
        pos_wr_data = r_cur.pos;

        unique case (r_state)
            S_IDLE: begin
                if (q_pop) begin
                    n_out_pos = i_cmd.pos;
                    load      = 1'b1;
                    unique case (i_cmd.kind)
                        K_TICK: begin
                            n_timer   = timer_inc;
                            n_out_dbl = i_cmd.dbl;
                            if (edge_item) begin
                                n_timer = '0;
                                if (!r_started) begin
                                    n_started   = 1'b1;
                                    n_slot      = SLOT_W'(1);
                                    mem_we      = 1'b1;
                                    mem_wr_addr = '0;
                                    int_wr_data = '0;
                                    pos_wr_data = i_cmd.pos;
                                end else begin
                                    load    = 1'b0;
                                    n_now   = timer_inc;
                                    n_cur   = i_cmd;
                                    n_state = S_UPD;
                                end
                            end
                        end
                        K_READ: begin
                            n_out_delta = i_cmd.delta;
                            if (i_cfg.measure_en && r_timer > i_cfg.timeout) begin
                                n_out_tout = 1'b1;
                                n_started  = 1'b0;
                                n_full     = 1'b0;
                                n_slot     = '0;
                                n_timer    = '0;
                                n_sum      = '0;
                                n_speed    = '0;
                            end
                        end
                        K_RESET: begin
                            if (i_cfg.measure_en) begin
                                n_started = 1'b0;
                                n_full    = 1'b0;
                                n_slot    = '0;
                                n_timer   = '0;
                                n_sum     = '0;
                                n_speed   = '0;
                            end
                        end
                        K_NONE: begin
                        end
                    endcase
                end
            end
            S_UPD: begin
                mem_we = 1'b1;
                n_sum  = r_full ? r_sum - SUM_W'(old_int) + SUM_W'(r_now)
                                : r_sum + SUM_W'(r_now);
                n_slot = last_slot ? '0 : r_slot + 1'b1;
                if (last_slot) begin
                    n_full = 1'b1;
                end
                n_neg   = diff[POS_W-1];
                n_rem   = '0;
                n_dvd   = {mag, {Q_SHIFT{1'b0}}};
                n_cnt   = '0;
                n_state = (n_sum != '0) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem = ge ? rem_sh[SUM_W-1:0] - r_sum : rem_sh[SUM_W-1:0];
                n_dvd = {r_dvd[DIV_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    // quotient stays within the 48-bit signed range
                    n_speed = r_neg ? -n_dvd : n_dvd;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_pos = r_cur.pos;
                    load      = 1'b1;
                    n_state   = S_IDLE;
                end
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_speed = i_cfg.measure_en ? n_speed : '0;
        end else begin
            n_out_pos   = r_out_pos;
            n_out_delta = r_out_delta;
            n_out_speed = r_out_speed;
            n_out_dbl   = r_out_dbl;
            n_out_tout  = r_out_tout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_full      <= 1'b0;
            r_slot      <= '0;
            r_timer     <= '0;
            r_sum       <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_full      <= n_full;
            r_slot      <= n_slot;
            r_timer     <= n_timer;
            r_sum       <= n_sum;
            r_speed     <= n_speed;
            r_out_valid <= n_out_valid;
        end
        r_now       <= n_now;
        r_cur       <= n_cur;
        r_neg       <= n_neg;
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_cnt       <= n_cnt;
        r_out_pos   <= n_out_pos;
        r_out_delta <= n_out_delta;
        r_out_speed <= n_out_speed;
        r_out_dbl   <= n_out_dbl;
        r_out_tout  <= n_out_tout;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_int_mem[mem_wr_addr] <= int_wr_data;
            r_pos_mem[mem_wr_addr] <= pos_wr_data;
        end
        r_int_rd <= r_int_mem[r_slot];
        r_pos_rd <= r_pos_mem[pos_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_vld    <= '0;
            r_int_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_int_vld[mem_wr_addr] <= 1'b1;
            end
            r_int_rd_vld <= r_int_vld[r_slot];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_delta    = r_out_delta;
    assign o_speed    = r_out_speed;
    assign o_dbl      = r_out_dbl;
    assign o_tout     = r_out_tout;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("ring slot out of range");

    a_full_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_started)
        else $error("window full while stopped");

    a_timer_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_timer == '0)
        else $error("timer running while stopped");

    a_sum_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_sum == '0)
        else $error("window sum nonzero while stopped");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !q_pop)
        else $error("queue popped while an edge is in progress");

endmodule

### design/quadrature_decoder_speed_window_top.sv
// Top level of the quadrature decoder with windowed speed measurement.
// Holds the configuration registers; uses qdsw_pkg, qdsw_front, qdsw_queue, qdsw_back.
//
// Input stream (s_axis): one word per pin sample tick, read or count reset; the
// kind travels in tuser. Output stream (m_axis): exactly one result word per
// input word, in order. Config port: i_cfg_we writes i_cfg_wdata to register
// i_cfg_addr (0 decode mode, 1 measure enable, 2 timeout); write only while idle.
// Words without a measured edge pass through the command queue and then the
// output register. A counted edge with measurement on goes through the back
// end's ring update and a 48-step bit-serial divider; the divider is skipped if
// the window sum is zero, and the first edge after clearing only stores its sample.
// Throughput: one word per cycle while no measured edge is pending; the
// command queue absorbs QUEUE_DEPTH words behind a divide, then s_axis_tready
// drops. A stalled m_axis holds the result register; the front keeps taking
// words until the queue fills.
// Reset: synchronous, active low; counts, pins (both high), timer, window and
// speed clear, configuration returns to its defaults.
module quadrature_decoder_speed_window_top import qdsw_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] pin_a, [1] pin_b
    input  logic [1:0]            s_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [119:0]          m_axis_tdata,   // position, delta, speed_q16,
                                                  // double_edge, timed_out
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg               r_cfg;
    logic               q_full, q_push, q_pop, q_valid;
    t_cmd               push_cmd, pop_cmd;
    logic [POS_W-1:0]   res_pos, res_delta;
    logic [SPEED_W-1:0] res_speed;
    logic               res_dbl, res_tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode <= MODE_X1;
            r_cfg.measure_en  <= 1'b0;
            r_cfg.timeout     <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DECODE_MODE: r_cfg.decode_mode <= i_cfg_wdata[1:0];
                REG_MEASURE_EN:  r_cfg.measure_en  <= i_cfg_wdata[0];
                REG_TIMEOUT:     r_cfg.timeout     <= i_cfg_wdata[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    qdsw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_kind   (s_axis_tuser),
        .i_pin_a  (s_axis_tdata[0]),
        .i_pin_b  (s_axis_tdata[1]),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    qdsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_cmd)
    );

    qdsw_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_cmd      (pop_cmd),
        .i_cfg      (r_cfg),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_position (res_pos),
        .o_delta    (res_delta),
        .o_speed    (res_speed),
        .o_dbl      (res_dbl),
        .o_tout     (res_tout)
    );

    assign m_axis_tdata = {6'b0, res_tout, res_dbl, res_speed, res_delta, res_pos};

endmodule
